// ===== src/sic_pkg.sv =====
// Shared widths, the front-to-back item type and helper functions for the segment crossing core.
package sic_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int IN_W   = 16;   // width of one coordinate field on the input
    localparam int OUT_W  = 24;   // width of one crossing coordinate on the output
    localparam int CW     = 17;   // internal coordinate, signed
    localparam int DW     = 18;   // coordinate difference, signed
    localparam int PW     = 36;   // product of two differences, signed
    localparam int SW     = 37;   // difference of two products, signed
    localparam int MW     = 36;   // magnitude of the denominator and numerator
    localparam int AW     = 18;   // magnitude of a segment extent
    localparam int HW     = 18;   // half of a magnitude, for split multiplies

    localparam int S_TDATA_W = 8 * IN_W;
    localparam int M_TDATA_W = 56;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] asx;
        logic signed [CW-1:0] asy;
        logic signed [DW-1:0] dax;
        logic signed [DW-1:0] day;
        logic [MW-1:0]        den;
        logic [MW-1:0]        num;
    } sic_item_t;

    // Reads a raw field as an integer coordinate. Narrow coordinates are
    // sign-extended from their top bit; wide ones carry no sign bit.
    function automatic logic signed [CW-1:0] coord_of(logic [IN_W-1:0] raw, int cb);
        int        w;
        logic      sgn;
        logic [CW-1:0] r;
        w   = (cb < IN_W) ? cb : IN_W;
        sgn = (cb <= IN_W) ? raw[w-1] : 1'b0;
        for (int i = 0; i < IN_W; i++) begin
            r[i] = (i < w) ? raw[i] : sgn;
        end
        r[CW-1] = sgn;
        return $signed(r);
    endfunction

    function automatic logic signed [PW-1:0] smul(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
        return a * b;
    endfunction

    // a*b - c*d, the 2-D cross product form.
    function automatic logic signed [SW-1:0] xprod(logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b,
                                                    logic signed [DW-1:0] c,
                                                    logic signed [DW-1:0] d);
        return SW'(smul(a, b)) - SW'(smul(c, d));
    endfunction

endpackage

// ===== src/sic_front.sv =====
// Front part: takes input beats, computes the side tests and the line intersection terms.
module sic_front #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sic_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             full,
    output logic                             push,
    output sic_pkg::sic_item_t               item
);

    localparam int CW = sic_pkg::CW;
    localparam int DW = sic_pkg::DW;
    localparam int SW = sic_pkg::SW;
    localparam int MW = sic_pkg::MW;
    localparam int IW = sic_pkg::IN_W;

    logic adv;

    logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;

    // Stage 1: decoded start point of A and all differences.
    logic                 v1_reg;
    logic signed [CW-1:0] asx1_reg, asy1_reg;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [DW-1:0] asy_bsy_reg, asx_bsx_reg, aey_bsy_reg, aex_bsx_reg;
    logic signed [DW-1:0] bey_asy_reg, bex_asx_reg, bsy_asy_reg, bsx_asx_reg;

    // Stage 2: cross products.
    logic                 v2_reg;
    logic signed [CW-1:0] asx2_reg, asy2_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [SW-1:0] s1_reg, s2_reg, s3_reg, s4_reg, den_reg, num_reg;

    logic                 side_a, side_b;
    logic signed [SW-1:0] den_abs, num_adj;

    assign adv      = !(v2_reg && full);
    assign s_tready = adv;
    assign push     = v2_reg && !full;

    assign asx = sic_pkg::coord_of(s_tdata[0*IW +: IW], COORD_BITS);
    assign asy = sic_pkg::coord_of(s_tdata[1*IW +: IW], COORD_BITS);
    assign aex = sic_pkg::coord_of(s_tdata[2*IW +: IW], COORD_BITS);
    assign aey = sic_pkg::coord_of(s_tdata[3*IW +: IW], COORD_BITS);
    assign bsx = sic_pkg::coord_of(s_tdata[4*IW +: IW], COORD_BITS);
    assign bsy = sic_pkg::coord_of(s_tdata[5*IW +: IW], COORD_BITS);
    assign bex = sic_pkg::coord_of(s_tdata[6*IW +: IW], COORD_BITS);
    assign bey = sic_pkg::coord_of(s_tdata[7*IW +: IW], COORD_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            asx1_reg    <= asx;
            asy1_reg    <= asy;
            dax_reg     <= DW'(aex) - DW'(asx);
            day_reg     <= DW'(aey) - DW'(asy);
            dbx_reg     <= DW'(bex) - DW'(bsx);
            dby_reg     <= DW'(bey) - DW'(bsy);
            asy_bsy_reg <= DW'(asy) - DW'(bsy);
            asx_bsx_reg <= DW'(asx) - DW'(bsx);
            aey_bsy_reg <= DW'(aey) - DW'(bsy);
            aex_bsx_reg <= DW'(aex) - DW'(bsx);
            bey_asy_reg <= DW'(bey) - DW'(asy);
            bex_asx_reg <= DW'(bex) - DW'(asx);
            bsy_asy_reg <= DW'(bsy) - DW'(asy);
            bsx_asx_reg <= DW'(bsx) - DW'(asx);

            asx2_reg <= asx1_reg;
            asy2_reg <= asy1_reg;
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            s1_reg   <= sic_pkg::xprod(dbx_reg, asy_bsy_reg, dby_reg, asx_bsx_reg);
            s2_reg   <= sic_pkg::xprod(dbx_reg, aey_bsy_reg, dby_reg, aex_bsx_reg);
            s3_reg   <= sic_pkg::xprod(dax_reg, bey_asy_reg, day_reg, bex_asx_reg);
            s4_reg   <= sic_pkg::xprod(dax_reg, bsy_asy_reg, day_reg, bsx_asx_reg);
            den_reg  <= sic_pkg::xprod(dax_reg, dby_reg, day_reg, dbx_reg);
            num_reg  <= sic_pkg::xprod(bsx_asx_reg, dby_reg, bsy_asy_reg, dbx_reg);
        end
    end

    // A strict sign change on both pairs; a zero product never counts.
    always_comb begin
        side_a = (s1_reg > 0 && s2_reg < 0) || (s1_reg < 0 && s2_reg > 0);
        side_b = (s3_reg > 0 && s4_reg < 0) || (s3_reg < 0 && s4_reg > 0);
        den_abs = den_reg[SW-1] ? -den_reg : den_reg;
        num_adj = den_reg[SW-1] ? -num_reg : num_reg;
    end

    always_comb begin
        item.hit = side_a && side_b;
        item.asx = asx2_reg;
        item.asy = asy2_reg;
        item.dax = dax2_reg;
        item.day = day2_reg;
        item.den = den_abs[MW-1:0];
        item.num = num_adj[MW-1:0];
    end

endmodule

// ===== src/sic_fifo.sv =====
// Short queue between the front and back parts.
module sic_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sic_pkg::sic_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output sic_pkg::sic_item_t head
);

    localparam int DEPTH = sic_pkg::FIFO_DEPTH;
    localparam int PAW   = sic_pkg::FIFO_AW;

    sic_pkg::sic_item_t mem [DEPTH];
    logic [PAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PAW:0]   count_reg;

    assign full       = (count_reg == (PAW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/sic_back.sv =====
// Back part: split multiplies, pipelined restoring dividers and final rounding for x and y.
module sic_back #(
    parameter int FRAC_BITS = sic_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  sic_pkg::sic_item_t             head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sic_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CW = sic_pkg::CW;
    localparam int DW = sic_pkg::DW;
    localparam int MW = sic_pkg::MW;
    localparam int AW = sic_pkg::AW;
    localparam int HW = sic_pkg::HW;
    localparam int OW = sic_pkg::OUT_W;
    localparam int QB = AW + FRAC_BITS;
    localparam int WW = (FRAC_BITS + 20 > 25) ? FRAC_BITS + 20 : 25;
    localparam logic signed [WW-1:0] OMAX = WW'(sic_pkg::OUT_MAX);
    localparam logic signed [WW-1:0] OMIN = WW'(sic_pkg::OUT_MIN);
    localparam logic signed [WW-1:0] ONE  = WW'(1);
    localparam int M_TDATA_W_L = sic_pkg::M_TDATA_W;

    logic adv;

    // Stage A: partial products of |extent| times the numerator halves.
    logic                 va_reg;
    logic                 hita_reg, negxa_reg, negya_reg;
    logic signed [CW-1:0] asxa_reg, asya_reg;
    logic [MW-1:0]        dena_reg;
    logic [2*HW-1:0]      plx_reg, phx_reg, ply_reg, phy_reg;
    logic [AW-1:0]        adx, ady;

    // Divider stages, index 0 is loaded from stage A.
    logic                 dv_v   [QB+1];
    logic                 dv_hit [QB+1];
    logic                 dv_nx  [QB+1];
    logic                 dv_ny  [QB+1];
    logic signed [CW-1:0] dv_cx  [QB+1];
    logic signed [CW-1:0] dv_cy  [QB+1];
    logic [MW-1:0]        dv_den [QB+1];
    logic [MW-1:0]        dv_rx  [QB+1];
    logic [MW-1:0]        dv_ry  [QB+1];
    logic [QB-1:0]        dv_lx  [QB+1];
    logic [QB-1:0]        dv_ly  [QB+1];

    logic [MW+HW-1:0]     prodx, prody;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W_L-1:0] m_tdata_reg;
    logic [OW-1:0]        fx, fy;

    assign adv      = !m_tvalid_reg || m_tready;
    assign pop      = adv && head_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign adx = head.dax[DW-1] ? AW'(-head.dax) : AW'(head.dax);
    assign ady = head.day[DW-1] ? AW'(-head.day) : AW'(head.day);

    always_ff @(posedge aclk) begin
        if (adv) begin
            hita_reg  <= head.hit;
            negxa_reg <= head.dax[DW-1];
            negya_reg <= head.day[DW-1];
            asxa_reg  <= head.asx;
            asya_reg  <= head.asy;
            dena_reg  <= head.den;
            plx_reg   <= adx * head.num[HW-1:0];
            phx_reg   <= adx * head.num[MW-1:HW];
            ply_reg   <= ady * head.num[HW-1:0];
            phy_reg   <= ady * head.num[MW-1:HW];
        end
    end

    assign prodx = {phx_reg, {HW{1'b0}}} + (MW+HW)'(plx_reg);
    assign prody = {phy_reg, {HW{1'b0}}} + (MW+HW)'(ply_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= head_valid;
        end
    end

    // The top part of the dividend is already below the denominator, so the
    // remaining low bits (with the fraction zeros) go in one per stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_hit[0] <= hita_reg;
            dv_nx[0]  <= negxa_reg;
            dv_ny[0]  <= negya_reg;
            dv_cx[0]  <= asxa_reg;
            dv_cy[0]  <= asya_reg;
            dv_den[0] <= dena_reg;
            dv_rx[0]  <= prodx[MW+HW-1:HW];
            dv_ry[0]  <= prody[MW+HW-1:HW];
            dv_lx[0]  <= QB'(prodx[HW-1:0]) << FRAC_BITS;
            dv_ly[0]  <= QB'(prody[HW-1:0]) << FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v[0] <= 1'b0;
        end else if (adv) begin
            dv_v[0] <= va_reg;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [MW:0]   tx, ty;
        logic          gex, gey;
        logic [MW:0]   sx, sy;

        always_comb begin
            tx  = {dv_rx[k], dv_lx[k][QB-1]};
            ty  = {dv_ry[k], dv_ly[k][QB-1]};
            gex = tx >= {1'b0, dv_den[k]};
            gey = ty >= {1'b0, dv_den[k]};
            sx  = gex ? tx - {1'b0, dv_den[k]} : tx;
            sy  = gey ? ty - {1'b0, dv_den[k]} : ty;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_hit[k+1] <= dv_hit[k];
                dv_nx[k+1]  <= dv_nx[k];
                dv_ny[k+1]  <= dv_ny[k];
                dv_cx[k+1]  <= dv_cx[k];
                dv_cy[k+1]  <= dv_cy[k];
                dv_den[k+1] <= dv_den[k];
                dv_rx[k+1]  <= sx[MW-1:0];
                dv_ry[k+1]  <= sy[MW-1:0];
                dv_lx[k+1]  <= {dv_lx[k][QB-2:0], gex};
                dv_ly[k+1]  <= {dv_ly[k][QB-2:0], gey};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v[k+1] <= 1'b0;
            end else if (adv) begin
                dv_v[k+1] <= dv_v[k];
            end
        end
    end

    // Start coordinate plus the signed quotient, turned from floor division
    // into truncation toward zero, then clamped to the output range.
    function automatic logic [OW-1:0] finish(logic signed [CW-1:0] c, logic neg,
                                             logic [QB-1:0] q, logic nz);
        logic signed [WW-1:0] cw;
        logic signed [WW-1:0] qw;
        logic signed [WW-1:0] w0;
        logic signed [WW-1:0] w;
        cw = WW'(c) <<< FRAC_BITS;
        qw = $signed(WW'(q));
        w0 = neg ? cw - qw : cw + qw;
        if (nz && !neg && w0 < 0) begin
            w = w0 + ONE;
        end else if (nz && neg && w0 > 0) begin
            w = w0 - ONE;
        end else begin
            w = w0;
        end
        if (w > OMAX) begin
            return OMAX[OW-1:0];
        end else if (w < OMIN) begin
            return OMIN[OW-1:0];
        end
        return w[OW-1:0];
    endfunction

    always_comb begin
        fx = finish(dv_cx[QB], dv_nx[QB], dv_lx[QB], dv_rx[QB] != '0);
        fy = finish(dv_cy[QB], dv_ny[QB], dv_ly[QB], dv_ry[QB] != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_v[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dv_hit[QB]) begin
                m_tdata_reg <= M_TDATA_W_L'({fy, fx, 1'b1});
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

endmodule

// ===== src/segment_intersection_core.sv =====
// Top level of the segment crossing core: front part, queue and back part.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: two segments, 8 x 16-bit coords
//  m_      | out | m_tvalid/m_tready  | m_tdata: hit, cross_x, cross_y
//
// One beat per cycle in and out when nothing stalls. A result passes
// through two front stages, the queue, two multiply stages, one divider
// stage per quotient bit and the output register. Reset clears all valid
// flags and the queue. A stall on m_ holds the back part; the front part
// keeps taking beats until the queue fills.
module segment_intersection_core #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [sic_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit [0], cross_x [24:1], cross_y [48:25], zeros above
    output logic [sic_pkg::M_TDATA_W-1:0]  m_tdata
);

    sic_pkg::sic_item_t wr_item;
    sic_pkg::sic_item_t head;
    logic push, full, pop, head_valid;

    sic_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .item     (wr_item)
    );

    sic_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .wr_item    (wr_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sic_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== sim/tb_segment_intersection_core.sv =====
// Testbench for the segment crossing core: directed and random segment pairs, checked in order.
module tb_segment_intersection_core;

    localparam int FRAC = sic_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 24;
    localparam int OW = sic_pkg::OUT_W;
    localparam int SDW = sic_pkg::S_TDATA_W;
    localparam int MDW = sic_pkg::M_TDATA_W;

    typedef struct packed {
        logic                 hit;
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
    } crossing_t;

    int err_count = 0;
    int hit_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    class crossing_board;
        crossing_t pending[$];

        // trunc((c + d*num/den) * 2^FRAC), den > 0, saturated to the output range.
        function automatic longint fixed_pt(longint c, longint d, longint num, longint den);
            longint p, q, r, q2, r2, w;
            p = d * num;
            q = p / den;
            r = p % den;
            q2 = (r * (64'sd1 << FRAC)) / den;
            r2 = (r * (64'sd1 << FRAC)) % den;
            w = (c + q) * (64'sd1 << FRAC) + q2;
            if (r2 > 0 && w < 0) w = w + 1;
            else if (r2 < 0 && w > 0) w = w - 1;
            if (w > sic_pkg::OUT_MAX) w = sic_pkg::OUT_MAX;
            if (w < sic_pkg::OUT_MIN) w = sic_pkg::OUT_MIN;
            return w;
        endfunction

        function automatic int sgn(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function void note_pair(logic [SDW-1:0] d);
            longint c[8];
            longint dax, day, dbx, dby, s1, s2, s3, s4, den, num;
            crossing_t e;
            for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
            dax = c[2] - c[0]; day = c[3] - c[1];
            dbx = c[6] - c[4]; dby = c[7] - c[5];
            s1 = dbx * (c[1] - c[5]) - dby * (c[0] - c[4]);
            s2 = dbx * (c[3] - c[5]) - dby * (c[2] - c[4]);
            s3 = dax * (c[7] - c[1]) - day * (c[6] - c[0]);
            s4 = dax * (c[5] - c[1]) - day * (c[4] - c[0]);
            e = '0;
            if (sgn(s1) * sgn(s2) < 0 && sgn(s3) * sgn(s4) < 0) begin
                den = dax * dby - day * dbx;
                num = (c[4] - c[0]) * dby - (c[5] - c[1]) * dbx;
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                if (den != 0) begin
                    e.hit = 1'b1;
                    e.cx = OW'(fixed_pt(c[0], dax, num, den));
                    e.cy = OW'(fixed_pt(c[1], day, num, den));
                end
            end
            pending.push_back(e);
        endfunction

        task check_beat(logic [MDW-1:0] d);
            crossing_t e;
            if (pending.size() == 0) begin
                report("unexpected beat, hit", d[0], 0);
                return;
            end
            e = pending.pop_front();
            if (d[0] != e.hit) report("hit", d[0], e.hit);
            if (d[24:1] != e.cx) report("cross_x", $signed(d[24:1]), e.cx);
            if (d[48:25] != e.cy) report("cross_y", $signed(d[48:25]), e.cy);
            if (d[55:49] != '0) report("pad bits", d[55:49], 0);
            if (e.hit) hit_count++;
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDW-1:0] m_tdata;
    logic stim_done = 1'b0;

    crossing_board board = new();

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    segment_intersection_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Receiver stalls in stretches; some stretches never stall.
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_beat(m_tdata);
        if (aresetn && s_tvalid && s_tready) board.note_pair(s_tdata);
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // Holds one beat until accepted; gap_left inserts idle cycles before a burst.
    // Within a burst the next beat is driven at the edge that took the last one.
    int gap_left = 0;
    int burst_left = 0;
    task automatic send_pair(input logic [SDW-1:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            while (gap_left > 0) begin
                @(posedge aclk);
                gap_left--;
            end
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    function automatic logic [SDW-1:0] pack8(int v[8]);
        logic [SDW-1:0] d;
        for (int i = 0; i < 8; i++) d[16*i +: 16] = 16'(v[i]);
        return d;
    endfunction

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [SDW-1:0] d;
        logic [15:0] p;
        int m;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: proper cross, extremes, touching, collinear, parallel, vertical.
        send_pair(pack8('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
        send_pair(pack8('{0, 0, 10, 10, 0, 10, 10, 0}));
        send_pair(pack8('{0, 0, 10, 10, 5, 5, 10, 0}));
        send_pair(pack8('{0, 0, 10, 10, 2, 2, 20, 20}));
        send_pair(pack8('{0, 0, 10, 0, 0, 1, 10, 1}));
        send_pair(pack8('{3, -5, 3, 5, -1, 1, 7, 2}));
        send_pair(pack8('{-4, 1, 9, 2, 2, -7, 2, 8}));
        send_pair(pack8('{0, 0, 3, 1, 1, 0, 2, 1}));
        send_pair(pack8('{-1, -1, -32768, -32768, -32768, -1, -1, -32768}));
        send_pair(pack8('{32767, 0, -32768, 1, 0, 32767, 1, -32768}));
        send_pair(pack8('{0, 0, 1, 1, 1, 0, 0, 1}));
        send_pair(pack8('{0, 0, 0, 0, -1, -1, 1, 1}));
        send_pair(pack8('{0, 0, 10, 0, 5, -3, 5, 0}));
        send_pair(pack8('{-32768, 0, 32767, 0, 0, -32768, 0, 32767}));
        drain();
        gap_left = 20;
        burst_left = 0;
        for (int n = 0; n < 1250; n++) begin
            m = $urandom_range(0, 2);
            for (int i = 0; i < 8; i++) d[16*i +: 16] = rand_coord(m);
            // Most pairs are built so both segments share their midpoint.
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 2; i++) begin
                    p = rand_coord(2);
                    d[32 + 16*i +: 16] = 16'(2 * $signed(p) - $signed(d[16*i +: 16]));
                    d[96 + 16*i +: 16] = 16'(2 * $signed(p) - $signed(d[64 + 16*i +: 16]));
                end
            end
            send_pair(d);
            if (n == 600) begin
                drain();
                burst_left = 0;
            end
        end
        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        stim_done <= 1'b1;
    end

    initial begin
        wait (stim_done);
        @(posedge aclk);
        $display("Covered directed edge cases and random pairs under burst and stall traffic;");
        $display("%0d crossings were seen.", hit_count);
        if (err_count == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
src/sic_pkg.sv
src/sic_front.sv
src/sic_fifo.sv
src/sic_back.sv
src/segment_intersection_core.sv
sim/tb_segment_intersection_core.sv
